// ----- src/crc_checked_frame_receiver_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the CRC checked frame receiver
// Shared implication forms, one clock edge and one reset for every property.
// ---------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH
`define CRC_CHECKED_FRAME_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- src/crcfr_pkg.sv -----
// ---------------------------------------------------------------------------
// CRC frame receiver package
// Sizes, request and result types and codes shared by the receiver modules.
// ---------------------------------------------------------------------------
package crcfr_pkg;

    // Frame buffer size and the widths that follow from it.
    localparam int BUFFER_BYTES = 64;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);

    // Result queue between the front and back parts.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Framing and CRC-16/CCITT-FALSE constants.
    localparam logic [7:0]  HEADER_BYTE = 8'hBB;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_MSB     = 16'h8000;
    localparam int          MIN_FRAME   = 8;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_READ    = 2'd1,
        MODE_RESTART = 2'd2
    } t_mode;

    // Result kinds.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic [5:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [6:0] frame_length;
        logic [7:0] command_code;
        logic       crc_ok;
        logic [7:0] read_data;
        logic [6:0] good_length;
    } t_out_item;

endpackage

// ----- src/crcfr_ram.sv -----
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module crcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Storage write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/crcfr_front.sv -----
// ---------------------------------------------------------------------------
// CRC frame receiver front end
// Classifies requests, tracks the frame, folds the CRC and fills the buffer.
// ---------------------------------------------------------------------------
module crcfr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  crcfr_pkg::t_in_item   i_item,
    output logic                  o_push,
    output crcfr_pkg::t_out_item  o_push_item
);

    localparam int AW = crcfr_pkg::BUF_AW;
    localparam int CW = crcfr_pkg::CNT_W;
    localparam int BUFFER_BITS = crcfr_pkg::BUFFER_BYTES;

    // Buffer positions that carry header fields.
    localparam logic [CW-1:0] POS_CMD    = CW'(2);
    localparam logic [CW-1:0] POS_LEN_HI = CW'(3);
    localparam logic [CW-1:0] POS_LEN_LO = CW'(4);
    localparam logic [CW-1:0] POS_CRC    = CW'(3);

    // One byte of CRC-16/CCITT-FALSE, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & crcfr_pkg::CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ crcfr_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [CW-1:0]           r_count, n_count;
    logic [15:0]             r_crc, n_crc;
    logic [6:0]              r_good, n_good;
    logic [7:0]              r_prev1, r_prev2;
    logic [7:0]              r_cmd, r_len_hi, r_len_lo;
    logic [BUFFER_BITS-1:0]  r_vld;
    logic                    r_s1_valid;
    logic                    r_s1_hit;
    crcfr_pkg::t_out_item    r_s1_item, n_s1_item;

    logic          is_byte, is_read, is_restart;
    logic          idle, full;
    logic          store_hdr, store_body, drop_full, we;
    logic [AW-1:0] waddr, raddr;
    logic [CW-1:0] count_inc;
    logic [15:0]   crc_upd;
    logic          frame_end, crc_match;
    logic          idx_in_range;
    logic [7:0]    ram_rdata;

    // Request classification.
    always_comb begin
        is_byte    = i_accept && (i_item.mode == crcfr_pkg::MODE_BYTE);
        is_read    = i_accept && (i_item.mode == crcfr_pkg::MODE_READ);
        is_restart = i_accept && (i_item.mode == crcfr_pkg::MODE_RESTART);
        idle       = (r_count == '0);
        full       = (r_count >= CW'(crcfr_pkg::BUFFER_BYTES));
        store_hdr  = is_byte && idle && (i_item.byte_value == crcfr_pkg::HEADER_BYTE);
        store_body = is_byte && !idle && !full;
        drop_full  = is_byte && !idle && full;
        we         = store_hdr || store_body;
        waddr      = AW'(r_count);
        raddr      = AW'(i_item.read_index);
        idx_in_range = (32'(i_item.read_index) < crcfr_pkg::BUFFER_BYTES);
    end

    // CRC trails the writes by two bytes; the last two bytes are the check word.
    always_comb begin
        count_inc = r_count + CW'(1);
        crc_upd   = (r_count >= POS_CRC) ? crc_fold(r_crc, r_prev2) : r_crc;
        crc_match = ({r_prev1, i_item.byte_value} == crc_upd);
        frame_end = store_body
                 && (count_inc >= CW'(crcfr_pkg::MIN_FRAME))
                 && ((17'({r_len_hi, r_len_lo}) + 17'(crcfr_pkg::MIN_FRAME))
                     == 17'(count_inc));
    end

    // Next receiver state.
    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_good  = r_good;
        if (is_restart) begin
            n_count = '0;
            n_crc   = crcfr_pkg::CRC_INIT;
            n_good  = '0;
        end else if (store_hdr) begin
            n_count = CW'(1);
            n_crc   = crcfr_pkg::CRC_INIT;
        end else if (drop_full) begin
            n_count = '0;
            n_crc   = crcfr_pkg::CRC_INIT;
        end else if (frame_end) begin
            n_count = '0;
            n_crc   = crcfr_pkg::CRC_INIT;
            if (crc_match) begin
                n_good = 7'(count_inc);
            end
        end else if (store_body) begin
            n_count = count_inc;
            n_crc   = crc_upd;
        end
    end

    // Result descriptor for a frame end or a read.
    always_comb begin
        n_s1_item = '0;
        if (is_read) begin
            n_s1_item.result_kind = crcfr_pkg::KIND_READ;
            n_s1_item.good_length = r_good;
        end else begin
            n_s1_item.result_kind  = crcfr_pkg::KIND_FRAME;
            n_s1_item.frame_length = 7'(count_inc);
            n_s1_item.command_code = r_cmd;
            n_s1_item.crc_ok       = crc_match;
            n_s1_item.good_length  = n_good;
        end
    end

    // Control state and buffer valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= crcfr_pkg::CRC_INIT;
            r_good     <= '0;
            r_vld      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_good     <= n_good;
            r_s1_valid <= is_read || frame_end;
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
        end
    end

    // Byte history, header fields and the staged descriptor.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_prev1 <= i_item.byte_value;
            r_prev2 <= r_prev1;
        end
        if (store_body && (r_count == POS_CMD)) begin
            r_cmd <= i_item.byte_value;
        end
        if (store_body && (r_count == POS_LEN_HI)) begin
            r_len_hi <= i_item.byte_value;
        end
        if (store_body && (r_count == POS_LEN_LO)) begin
            r_len_lo <= i_item.byte_value;
        end
        if (is_read || frame_end) begin
            r_s1_item <= n_s1_item;
            r_s1_hit  <= idx_in_range && r_vld[raddr];
        end
    end

    crcfr_ram #(
        .WIDTH (8),
        .DEPTH (crcfr_pkg::BUFFER_BYTES)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.byte_value),
        .i_re    (is_read),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Merge the buffer read data into the staged result; unwritten entries read as zero.
    always_comb begin
        o_push      = r_s1_valid;
        o_push_item = r_s1_item;
        o_push_item.read_data =
            ((r_s1_item.result_kind == crcfr_pkg::KIND_READ) && r_s1_hit) ? ram_rdata : 8'h00;
    end

endmodule

// ----- src/crcfr_queue.sv -----
// ---------------------------------------------------------------------------
// CRC frame receiver result queue
// Short FIFO whose head drives the result channel.
// ---------------------------------------------------------------------------
module crcfr_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  crcfr_pkg::t_out_item            i_push_item,
    input  logic                            i_stall,
    output logic                            o_valid,
    output crcfr_pkg::t_out_item            o_head,
    output logic [crcfr_pkg::QCNT_W-1:0]    o_count
);

    localparam int PW = crcfr_pkg::QPTR_W;
    localparam int NW = crcfr_pkg::QCNT_W;

    crcfr_pkg::t_out_item r_slot [crcfr_pkg::QUEUE_DEPTH];
    logic [PW-1:0]        r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]        r_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + NW'(i_push) - NW'(pop);
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// ----- src/crc_checked_frame_receiver_unit.sv -----
// A read or frame-ending byte is registered as a staged result, then written to the result queue.
// Throughput: one request per cycle while o_in_stall is low, set by the combinational CRC byte fold.
// Requests stall only while the result queue cannot take what is in flight.
// Reset is synchronous and active low: receiver idle, CRC 0xFFFF, good length zero,
// every buffer entry reads as zero until written; no clearing pass is needed.
// ---------------------------------------------------------------------------
// CRC checked frame receiver
// Front end tracks frames and the buffer; a result queue feeds the output.
// ---------------------------------------------------------------------------
`include "crc_checked_frame_receiver_unit_macros.svh"

module crc_checked_frame_receiver_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  crcfr_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output crcfr_pkg::t_out_item  o_out_data
);

    localparam int FW = crcfr_pkg::QCNT_W + 1;

    logic                          in_accept;
    logic                          push;
    crcfr_pkg::t_out_item          push_item;
    logic [crcfr_pkg::QCNT_W-1:0]  q_count;
    logic [FW-1:0]                 fill;

    // Hold requests while the staged result could not find a queue slot.
    assign fill       = FW'(q_count) + FW'(push);
    assign o_in_stall = (fill >= FW'(crcfr_pkg::QUEUE_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    crcfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .o_push      (push),
        .o_push_item (push_item)
    );

    crcfr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_head      (o_out_data),
        .o_count     (q_count)
    );

    // The queue always has room for a staged result.
    `CRCFR_ASSERT_SAME(a_queue_room, i_clk, i_rst_n, push, q_count < crcfr_pkg::QCNT_W'(crcfr_pkg::QUEUE_DEPTH))

    // A read request yields a read result in the following cycle.
    `CRCFR_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, in_accept && (i_in_data.mode == crcfr_pkg::MODE_READ), push && (push_item.result_kind == crcfr_pkg::KIND_READ))

    // A frame with a good CRC becomes the last good frame.
    `CRCFR_ASSERT_SAME(a_good_length, i_clk, i_rst_n, o_out_valid && (o_out_data.result_kind == crcfr_pkg::KIND_FRAME) && o_out_data.crc_ok, o_out_data.good_length == o_out_data.frame_length)

endmodule
